>>> hdl/catmull_rom_stroke_interpolator_top_macros.svh
// assertion macros used by the catmull-rom stroke interpolator back end
`ifndef CATMULL_ROM_STROKE_INTERPOLATOR_TOP_MACROS_SVH
`define CATMULL_ROM_STROKE_INTERPOLATOR_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRSI_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("crsi assertion failed");

// next-cycle implication, disabled during reset
`define CRSI_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("crsi assertion failed");

`endif

>>> hdl/crsi_pkg.sv
// shared types and constants of the catmull-rom stroke interpolator
`default_nettype none

package crsi_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_LIMIT  = 1'b0,
    REG_TENSION_SCALE = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_DATA_W-1:0] OUTPUT_LIMIT_RST  = 16'd65535;
  localparam logic [CFG_DATA_W-1:0] TENSION_SCALE_RST = 16'd8192;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] output_limit;
    logic [CFG_DATA_W-1:0] tension_scale;
  } cfg_t;

  typedef enum logic {
    CMD_SEG = 1'b0,
    CMD_END = 1'b1
  } cmd_kind_t;

  // kind and closing flag ahead of the eight coordinates
  localparam int unsigned CMD_CTRL_W   = 2;
  localparam int unsigned T_FRAC       = 16;
  localparam int unsigned TENSION_FRAC = 14;
  localparam int unsigned QUEUE_DEPTH  = 4;

endpackage

`default_nettype wire

>>> hdl/crsi_cmd_fifo.sv
// command queue between the point front end and the sample back end
`default_nettype none

module crsi_cmd_fifo #(
  parameter int unsigned WIDTH = 130,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic      [WIDTH-1:0] pop_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign push_ready = (cnt_r != CNT_W'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/crsi_front.sv
// point window and segment classification, issues segment and endpoint commands
`default_nettype none

module crsi_front #(
  parameter int unsigned CW    = 16,
  parameter int unsigned CMD_W = crsi_pkg::CMD_CTRL_W + 8 * CW
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [CW-1:0]    in_point_x,
  input  wire logic [CW-1:0]    in_point_y,
  input  wire logic             in_stroke_last,
  output logic                  cmd_valid,
  input  wire logic             cmd_ready,
  output logic      [CMD_W-1:0] cmd_data
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_SEGA,
    F_SEGB,
    F_END
  } state_t;

  typedef enum logic [1:0] {
    PS_NONE,
    PS_ONE,
    PS_MANY
  } pts_t;

  typedef struct packed {
    crsi_pkg::cmd_kind_t kind;
    logic                closing;
    logic [3:0][CW-1:0]  px;
    logic [3:0][CW-1:0]  py;
  } cmd_t;

  state_t             state_r, state_nxt;
  pts_t               ps_r, ps_nxt;
  logic [2:0][CW-1:0] wx_r, wx_nxt;
  logic [2:0][CW-1:0] wy_r, wy_nxt;
  logic [CW-1:0]      hx_r, hx_nxt;
  logic [CW-1:0]      hy_r, hy_nxt;
  logic               hlast_r, hlast_nxt;
  logic               accept;
  cmd_t               cmd;

  assign in_ready  = (state_r == F_IDLE);
  assign accept    = in_valid && in_ready;
  assign cmd_valid = (state_r != F_IDLE);

  always_comb begin
    cmd.kind    = (state_r == F_END) ? crsi_pkg::CMD_END : crsi_pkg::CMD_SEG;
    cmd.closing = hlast_r;
    cmd.px      = {hx_r, wx_r[2], wx_r[1], wx_r[0]};
    cmd.py      = {hy_r, wy_r[2], wy_r[1], wy_r[0]};
  end

  assign cmd_data = cmd;

  always_comb begin
    state_nxt = state_r;
    ps_nxt    = ps_r;
    wx_nxt    = wx_r;
    wy_nxt    = wy_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    hlast_nxt = hlast_r;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          hx_nxt    = in_point_x;
          hy_nxt    = in_point_y;
          hlast_nxt = in_stroke_last;
          case (ps_r)
            PS_NONE: begin
              // first point doubles as the leading ghost point
              wx_nxt[1] = in_point_x;
              wx_nxt[2] = in_point_x;
              wy_nxt[1] = in_point_y;
              wy_nxt[2] = in_point_y;
              if (!in_stroke_last) begin
                ps_nxt = PS_ONE;
              end
            end
            PS_ONE: begin
              wx_nxt = {in_point_x, wx_r[2], wx_r[1]};
              wy_nxt = {in_point_y, wy_r[2], wy_r[1]};
              ps_nxt = PS_MANY;
              if (in_stroke_last) begin
                state_nxt = F_SEGB;
              end
            end
            PS_MANY: begin
              state_nxt = F_SEGA;
            end
            default: begin
              ps_nxt = PS_NONE;
            end
          endcase
        end
      end
      F_SEGA: begin
        if (cmd_ready) begin
          wx_nxt    = {hx_r, wx_r[2], wx_r[1]};
          wy_nxt    = {hy_r, wy_r[2], wy_r[1]};
          state_nxt = hlast_r ? F_SEGB : F_IDLE;
        end
      end
      F_SEGB: begin
        if (cmd_ready) begin
          state_nxt = F_END;
        end
      end
      F_END: begin
        if (cmd_ready) begin
          ps_nxt    = PS_NONE;
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      ps_r    <= PS_NONE;
      hlast_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ps_r    <= ps_nxt;
      hlast_r <= hlast_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wx_r <= wx_nxt;
    wy_r <= wy_nxt;
    hx_r <= hx_nxt;
    hy_r <= hy_nxt;
  end

endmodule

`default_nettype wire

>>> hdl/crsi_back.sv
// sample sequencer and spline evaluation pipeline with output register
`default_nettype none

`include "catmull_rom_stroke_interpolator_top_macros.svh"

module crsi_back #(
  parameter int unsigned CW    = 16,
  parameter int unsigned S     = 20,
  parameter int unsigned CMD_W = crsi_pkg::CMD_CTRL_W + 8 * CW
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_valid,
  output logic                  cmd_ready,
  input  wire logic [CMD_W-1:0] cmd_data,
  input  wire crsi_pkg::cfg_t   cfg,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [CW-1:0]    out_x,
  output logic      [CW-1:0]    out_y,
  output logic                  out_run_end,
  output logic                  out_stroke_end
);

  localparam int unsigned IDX_W = $clog2(S);
  localparam int unsigned TW    = crsi_pkg::T_FRAC;
  localparam int unsigned LW    = crsi_pkg::CFG_DATA_W;
  localparam int unsigned CFW   = CW + 4;
  localparam int unsigned PRW   = CFW + TW + 1;
  localparam int unsigned SUMW  = CW + 23;
  localparam int unsigned POLYW = SUMW - TW;
  localparam int unsigned SCW   = POLYW + LW + 1;

  localparam logic signed [SUMW-1:0] RND_POLY = SUMW'(longint'(1) <<< (TW - 1));
  localparam logic signed [SCW-1:0]  RND_SC   =
    SCW'(longint'(1) <<< (crsi_pkg::TENSION_FRAC - 1));
  localparam logic signed [SCW-1:0]  SAT_HI   = SCW'((longint'(1) <<< (CW - 1)) - 1);
  localparam logic signed [SCW-1:0]  SAT_LO   = -SAT_HI - SCW'(1);

  typedef enum logic {
    B_IDLE,
    B_SEG
  } state_t;

  typedef struct packed {
    crsi_pkg::cmd_kind_t kind;
    logic                closing;
    logic [3:0][CW-1:0]  px;
    logic [3:0][CW-1:0]  py;
  } cmd_t;

  typedef struct packed {
    logic signed [CFW-1:0] a;
    logic signed [CFW-1:0] b;
    logic signed [CFW-1:0] c;
    logic signed [CFW-1:0] d;
  } coef_t;

  function automatic coef_t coefs(input logic [3:0][CW-1:0] p);
    logic signed [CFW-1:0] p0, p1, p2, p3;
    coef_t                 k;
    p0  = CFW'($signed(p[0]));
    p1  = CFW'($signed(p[1]));
    p2  = CFW'($signed(p[2]));
    p3  = CFW'($signed(p[3]));
    k.a = p1 <<< 1;
    k.b = p2 - p0;
    k.c = (p0 <<< 1) - ((p1 <<< 2) + p1) + (p2 <<< 2) - p3;
    k.d = ((p1 <<< 1) + p1) - ((p2 <<< 1) + p2) + p3 - p0;
    return k;
  endfunction

  function automatic logic signed [PRW-1:0] prod(input logic signed [CFW-1:0] k,
                                                 input logic [TW-1:0] t);
    return PRW'(k) * PRW'($signed({1'b0, t}));
  endfunction

  function automatic logic signed [POLYW-1:0] poly_of(input logic signed [SUMW-1:0] a,
                                                      input logic signed [PRW-1:0] b,
                                                      input logic signed [PRW-1:0] c,
                                                      input logic signed [PRW-1:0] d);
    logic signed [SUMW-1:0] s;
    s = a + SUMW'(b) + SUMW'(c) + SUMW'(d) + RND_POLY;
    return POLYW'(s >>> TW);
  endfunction

  function automatic logic [CW-1:0] sat_round(input logic signed [SCW-1:0] v);
    logic signed [SCW-1:0] r;
    r = (v + RND_SC) >>> crsi_pkg::TENSION_FRAC;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return CW'(r);
  endfunction

  // t, t^2, t^3 in q0.16 for each sample of a segment
  logic [TW-1:0] t1_tab [S];
  logic [TW-1:0] t2_tab [S];
  logic [TW-1:0] t3_tab [S];

  for (genvar g = 0; g < S; g++) begin : g_ttab
    localparam longint T1 = (longint'(g) * 65536 + S / 2) / S;
    localparam longint T2 = (T1 * T1 + 32768) >>> 16;
    localparam longint T3 = (T2 * T1 + 32768) >>> 16;
    assign t1_tab[g] = TW'(T1);
    assign t2_tab[g] = TW'(T2);
    assign t3_tab[g] = TW'(T3);
  end

  cmd_t cmd;
  assign cmd = cmd_t'(cmd_data);

  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               closing_r, closing_nxt;
  logic [LW-1:0]      emit_cnt_r, emit_cnt_nxt;
  coef_t              cx_r, cx_nxt, cy_r, cy_nxt;
  logic [TW-1:0]      t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt;

  logic               adv;
  logic               iss_valid, iss_end, iss_run, iss_sen;
  logic [CW-1:0]      iss_rx, iss_ry;
  logic [LW:0]        e_ext, lim_ext;
  logic               can_sample, more_room, can_end, last_idx;
  logic [IDX_W-1:0]   idx_inc;

  logic               p1_valid_r, p1_end_r, p1_run_r, p1_sen_r;
  logic [CW-1:0]      p1_rx_r, p1_ry_r;
  logic signed [SUMW-1:0] p1_ax_r, p1_ay_r;
  logic signed [PRW-1:0]  p1_bx_r, p1_cx_r, p1_dx_r, p1_by_r, p1_cy_r, p1_dy_r;

  logic               p2_valid_r, p2_end_r, p2_run_r, p2_sen_r;
  logic [CW-1:0]      p2_rx_r, p2_ry_r;
  logic signed [POLYW-1:0] p2_px_r, p2_py_r;

  logic               p3_valid_r, p3_end_r, p3_run_r, p3_sen_r;
  logic [CW-1:0]      p3_rx_r, p3_ry_r;
  logic signed [SCW-1:0] p3_sx_r, p3_sy_r;

  logic               out_valid_r;
  logic [CW-1:0]      out_x_r, out_y_r;
  logic               out_run_end_r, out_stroke_end_r;

  assign adv        = !out_valid_r || out_ready;
  assign e_ext      = {1'b0, emit_cnt_r};
  assign lim_ext    = {1'b0, cfg.output_limit};
  assign can_sample = (e_ext + (LW + 1)'(1)) < lim_ext;
  assign more_room  = (e_ext + (LW + 1)'(2)) < lim_ext;
  assign can_end    = e_ext < lim_ext;
  assign last_idx   = (idx_r == IDX_W'(S - 1));
  assign idx_inc    = idx_r + IDX_W'(1);

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    closing_nxt  = closing_r;
    emit_cnt_nxt = emit_cnt_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    t1_nxt       = t1_r;
    t2_nxt       = t2_r;
    t3_nxt       = t3_r;
    cmd_ready    = 1'b0;
    iss_valid    = 1'b0;
    iss_end      = 1'b0;
    iss_run      = 1'b0;
    iss_sen      = 1'b0;
    iss_rx       = cmd.px[3];
    iss_ry       = cmd.py[3];
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == crsi_pkg::CMD_SEG) begin
            cmd_ready   = 1'b1;
            cx_nxt      = coefs(cmd.px);
            cy_nxt      = coefs(cmd.py);
            closing_nxt = cmd.closing;
            idx_nxt     = '0;
            t1_nxt      = t1_tab[0];
            t2_nxt      = t2_tab[0];
            t3_nxt      = t3_tab[0];
            state_nxt   = B_SEG;
          end else if (adv) begin
            // closing endpoint, then a fresh stroke
            cmd_ready    = 1'b1;
            iss_valid    = can_end;
            iss_end      = 1'b1;
            iss_run      = 1'b1;
            iss_sen      = 1'b1;
            emit_cnt_nxt = '0;
          end
        end
      end
      B_SEG: begin
        if (adv) begin
          if (can_sample) begin
            iss_valid    = 1'b1;
            iss_run      = !closing_r && (last_idx || !more_room);
            emit_cnt_nxt = emit_cnt_r + LW'(1);
            if (last_idx) begin
              state_nxt = B_IDLE;
            end else begin
              idx_nxt = idx_inc;
              t1_nxt  = t1_tab[idx_inc];
              t2_nxt  = t2_tab[idx_inc];
              t3_nxt  = t3_tab[idx_inc];
            end
          end else begin
            state_nxt = B_IDLE;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      idx_r       <= '0;
      closing_r   <= 1'b0;
      emit_cnt_r  <= '0;
      p1_valid_r  <= 1'b0;
      p2_valid_r  <= 1'b0;
      p3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      closing_r  <= closing_nxt;
      emit_cnt_r <= emit_cnt_nxt;
      if (adv) begin
        p1_valid_r  <= iss_valid;
        p2_valid_r  <= p1_valid_r;
        p3_valid_r  <= p2_valid_r;
        out_valid_r <= p3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    cx_r <= cx_nxt;
    cy_r <= cy_nxt;
    t1_r <= t1_nxt;
    t2_r <= t2_nxt;
    t3_r <= t3_nxt;
    if (adv) begin
      p1_end_r <= iss_end;
      p1_run_r <= iss_run;
      p1_sen_r <= iss_sen;
      p1_rx_r  <= iss_rx;
      p1_ry_r  <= iss_ry;
      p1_ax_r  <= SUMW'(cx_r.a) <<< TW;
      p1_bx_r  <= prod(cx_r.b, t1_r);
      p1_cx_r  <= prod(cx_r.c, t2_r);
      p1_dx_r  <= prod(cx_r.d, t3_r);
      p1_ay_r  <= SUMW'(cy_r.a) <<< TW;
      p1_by_r  <= prod(cy_r.b, t1_r);
      p1_cy_r  <= prod(cy_r.c, t2_r);
      p1_dy_r  <= prod(cy_r.d, t3_r);

      p2_end_r <= p1_end_r;
      p2_run_r <= p1_run_r;
      p2_sen_r <= p1_sen_r;
      p2_rx_r  <= p1_rx_r;
      p2_ry_r  <= p1_ry_r;
      p2_px_r  <= poly_of(p1_ax_r, p1_bx_r, p1_cx_r, p1_dx_r);
      p2_py_r  <= poly_of(p1_ay_r, p1_by_r, p1_cy_r, p1_dy_r);

      p3_end_r <= p2_end_r;
      p3_run_r <= p2_run_r;
      p3_sen_r <= p2_sen_r;
      p3_rx_r  <= p2_rx_r;
      p3_ry_r  <= p2_ry_r;
      p3_sx_r  <= SCW'(p2_px_r) * SCW'($signed({1'b0, cfg.tension_scale}));
      p3_sy_r  <= SCW'(p2_py_r) * SCW'($signed({1'b0, cfg.tension_scale}));

      out_x_r          <= p3_end_r ? p3_rx_r : sat_round(p3_sx_r);
      out_y_r          <= p3_end_r ? p3_ry_r : sat_round(p3_sy_r);
      out_run_end_r    <= p3_run_r;
      out_stroke_end_r <= p3_sen_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_x          = out_x_r;
  assign out_y          = out_y_r;
  assign out_run_end    = out_run_end_r;
  assign out_stroke_end = out_stroke_end_r;

  `CRSI_ASSERT_IMPL(a_stroke_end_ends_run, clk, rst_n,
                    out_valid_r && out_stroke_end_r, out_run_end_r)
  `CRSI_ASSERT_IMPL(a_idx_in_range, clk, rst_n,
                    state_r == B_SEG, idx_r <= IDX_W'(S - 1))
  `CRSI_ASSERT_NEXT(a_endpoint_clears_count, clk, rst_n,
                    cmd_valid && cmd_ready && (cmd.kind == crsi_pkg::CMD_END),
                    emit_cnt_r == '0)
  `CRSI_ASSERT_NEXT(a_stall_holds_pipe, clk, rst_n,
                    !adv, $stable(p1_valid_r) && $stable(p3_valid_r) && out_valid_r)

endmodule

`default_nettype wire

>>> hdl/catmull_rom_stroke_interpolator_top.sv
// catmull-rom stroke interpolator: config registers, front end, queue, back end
//
// in_*: stroke points (signed q12.4) with in_stroke_last on the final point,
//   valid/ready, one request at a time into the front end window.
// out_*: samples and the closing endpoint, valid/ready through an output
//   register; out_run_end marks the last result of a point, out_stroke_end
//   the endpoint.
// cfg_*: write-only port, cfg_index 0 output_limit, 1 tension_scale (q2.14).
// each segment gives up to SAMPLES_PER_SEGMENT samples (fewer once output_limit
//   is reached), one per cycle from the sample sequencer while out_ready does
//   not stall the output register.
// the front end takes a new point only once the last one's commands are queued
//   and waits while the queue is full, so throughput is set by the back end sequencer.
// from accept to first result a point passes the window, the queue, the
//   coefficient load and four pipeline stages ending in the output register.
// reset clears the window state, sample count and queue and restores
//   output_limit 65535 and tension_scale 8192; no clearing pass is needed.
// a stalled receiver freezes the whole evaluation pipeline; the queue then
//   fills and in_ready drops.
`default_nettype none

module catmull_rom_stroke_interpolator_top #(
  parameter int unsigned SAMPLES_PER_SEGMENT = 20,
  parameter int unsigned COORD_WIDTH         = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [COORD_WIDTH-1:0]              in_point_x,
  input  wire logic [COORD_WIDTH-1:0]              in_point_y,
  input  wire logic                                in_stroke_last,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic      [COORD_WIDTH-1:0]              out_x,
  output logic      [COORD_WIDTH-1:0]              out_y,
  output logic                                     out_run_end,
  output logic                                     out_stroke_end,
  input  wire logic                                cfg_we,
  input  wire logic [crsi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [crsi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned CMD_W = crsi_pkg::CMD_CTRL_W + 8 * COORD_WIDTH;

  crsi_pkg::cfg_t   cfg_r, cfg_nxt;
  logic             fq_valid, fq_ready;
  logic [CMD_W-1:0] fq_data;
  logic             qb_valid, qb_ready;
  logic [CMD_W-1:0] qb_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (crsi_pkg::cfg_reg_t'(cfg_index))
        crsi_pkg::REG_OUTPUT_LIMIT:  cfg_nxt.output_limit  = cfg_data;
        crsi_pkg::REG_TENSION_SCALE: cfg_nxt.tension_scale = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.output_limit  <= crsi_pkg::OUTPUT_LIMIT_RST;
      cfg_r.tension_scale <= crsi_pkg::TENSION_SCALE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  crsi_front #(
    .CW    (COORD_WIDTH),
    .CMD_W (CMD_W)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_stroke_last (in_stroke_last),
    .cmd_valid      (fq_valid),
    .cmd_ready      (fq_ready),
    .cmd_data       (fq_data)
  );

  crsi_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (crsi_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  crsi_back #(
    .CW    (COORD_WIDTH),
    .S     (SAMPLES_PER_SEGMENT),
    .CMD_W (CMD_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (qb_valid),
    .cmd_ready      (qb_ready),
    .cmd_data       (qb_data),
    .cfg            (cfg_r),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x          (out_x),
    .out_y          (out_y),
    .out_run_end    (out_run_end),
    .out_stroke_end (out_stroke_end)
  );

endmodule

`default_nettype wire
